// ----- design/chf_pkg.sv -----
// Shared constants and saturation functions for the Cholesky factor block.
package chf_pkg;
    localparam int MaxSize  = 8;
    localparam int FracBits = 16;
    localparam int Cells    = MaxSize * MaxSize;
    localparam int AddrW    = $clog2(Cells);
    localparam int IdxW     = $clog2(MaxSize);
    localparam int SzW      = 4;
    localparam int CntW     = 7;
    localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMin = 32'sh8000_0000;

    // saturate a 34-bit signed value to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) r = QMax;
        else if (v < -34'sh0_8000_0000) r = QMin;
        else r = v[31:0];
        return r;
    endfunction

    // product shift with floor, saturated
    function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
        logic signed [63:0] s;
        logic signed [31:0] r;
        s = p >>> FracBits;
        if (s > 64'sh7FFF_FFFF) r = QMax;
        else if (s < -64'sh8000_0000) r = QMin;
        else r = s[31:0];
        return r;
    endfunction
endpackage

// ----- design/cholesky_factor_top.sv -----
// Top level of the Cholesky factor block: load, factorize, drain.
//
// Usage
//   Input channel (i_valid / o_stall): one Q16.16 element per item, row-major,
//   n*n items per matrix, n = matrix_size (0 acts as 1, above 8 as 8). Upper
//   triangle items are accepted and dropped. Input stalls while a config
//   write is offered.
//   Config channel (i_cfg_valid / o_cfg_ready): writes matrix_size and discards
//   a partly loaded matrix. Write only while the block is idle.
//   Output channel (o_valid / i_stall): n*n factor items, row-major, zeros
//   above the diagonal, o_is_last on the final one, o_not_positive_definite
//   on all of them if any radicand was zero or less.
// Flow
//   Loading takes one item per cycle while no config write is offered. After
//   the last item the block stalls input while one shared multiply unit walks
//   the entries: a fetch of A, two store reads per inner product term, a square
//   root or a divide, and issue and advance. A zero or negative radicand skips
//   the unit. For an 8x8 matrix the divider dominates. The drain then gives
//   each item as a store read, then output, unless stalled.
// Reset
//   Synchronous, active low: size 8, load count 0, flag clear, outputs empty.
//   A stall holds the output item steady; the block waits.
module cholesky_factor_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_element_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_factor_value,
    output logic               o_is_last,
    output logic               o_not_positive_definite
);
    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_ACC   = 8'b0000_0010,  // issue read for A or an inner-product term
        S_MUL   = 8'b0000_0100,  // operands latched, multiply
        S_SUB   = 8'b0000_1000,  // accumulate
        S_OPER  = 8'b0001_0000,  // start sqrt/div
        S_WAIT  = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_RD    = 8'b1000_0000   // advance to next entry
    } t_state;

    localparam int AW = chf_pkg::AddrW;
    localparam int IW = chf_pkg::IdxW;

    t_state r_state;
    logic [3:0] r_size;
    logic [chf_pkg::CntW-1:0] r_cnt;
    logic [IW:0] r_row, r_col;     // load position
    logic        r_err;

    // factor store: A is overwritten in place by L (lower triangle)
    logic signed [31:0] mem [chf_pkg::Cells];
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] r_rd;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    logic [IW:0] n;
    logic [IW-1:0] r_i, r_j, r_k;
    logic [1:0]  r_ph;            // term read phase: 0 A, 1 L[i][k], 2 L[j][k]
    logic signed [31:0] r_acc, r_opa, r_diag;
    logic signed [63:0] r_prod;
    logic        r_prod_v;

    logic        a_start, a_done;
    logic signed [31:0] a_res;

    logic        r_ov;
    logic signed [31:0] r_ofv;
    logic        r_olast;
    logic        r_onpd;
    logic [IW-1:0] r_di, r_dj;
    logic        r_drd;           // drain read pending

    always_comb begin
        if (r_size == 4'd0) n = (IW+1)'(1);
        else if (r_size > 4'(chf_pkg::MaxSize)) n = (IW+1)'(chf_pkg::MaxSize);
        else n = r_size[IW:0];
    end

    function automatic logic [AW-1:0] adr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return {r, c};
    endfunction

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    chf_arith u_arith (
        .i_clk, .i_rst_n, .i_start(a_start), .i_is_sqrt(r_i == r_j),
        .i_a(r_acc), .i_d(r_diag), .o_done(a_done), .o_result(a_res)
    );

    assign o_stall     = (r_state != S_LOAD) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_LOAD);
    assign a_start     = (r_state == S_OPER) && !((r_i == r_j) ? (r_acc <= 0) : (r_diag <= 0));

    logic last_i;
    assign last_i = ({1'b0, r_i} == n - (IW+1)'(1));
    logic last_i_d;
    assign last_i_d = ({1'b0, r_di} == n - (IW+1)'(1));
    logic out_free;
    assign out_free = !r_ov || !i_stall;
    logic drain_go;
    assign drain_go = (r_state == S_DRAIN) && r_drd && out_free;

    always_comb begin
        rd_addr = adr(r_i, r_j);
        wr_en   = 1'b0;
        wr_addr = adr(r_row[IW-1:0], r_col[IW-1:0]);
        wr_data = i_element_value;
        unique case (r_state)
            S_LOAD: wr_en = i_valid && !i_cfg_valid && r_col <= r_row;
            S_ACC: begin
                unique case (r_ph)
                    2'd1:    rd_addr = adr(r_i, r_k);
                    2'd2:    rd_addr = adr(r_j, r_k);
                    default: rd_addr = adr(r_i, r_j);
                endcase
            end
            S_OPER: begin
                wr_addr = adr(r_i, r_j);
                wr_data = 32'sd0;
                wr_en   = (r_i == r_j) ? (r_acc <= 0) : (r_diag <= 0);
            end
            S_WAIT: begin
                wr_addr = adr(r_i, r_j);
                wr_data = a_res;
                wr_en   = a_done;
            end
            S_DRAIN: rd_addr = adr(r_di, r_dj);
            default: rd_addr = adr(r_j, r_j);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_size  <= 4'(chf_pkg::MaxSize);
            r_cnt   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_err   <= 1'b0;
            r_ov    <= 1'b0;
            r_drd   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            if (drain_go) r_ov <= 1'b1;
            else if (out_free) r_ov <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (i_cfg_valid) begin
                        r_size <= i_cfg_data;
                        r_cnt  <= '0;
                        r_row  <= '0;
                        r_col  <= '0;
                    end else if (i_valid) begin
                        if ({1'b0, r_cnt} + 8'd1 == 8'(n) * 8'(n)) begin
                            r_cnt   <= '0;
                            r_row   <= '0;
                            r_col   <= '0;
                            r_err   <= 1'b0;
                            r_j     <= '0;
                            r_i     <= '0;
                            r_k     <= '0;
                            r_ph    <= 2'd0;
                            r_state <= S_ACC;
                        end else begin
                            r_cnt <= r_cnt + 7'd1;
                            if (r_col == n - (IW+1)'(1)) begin
                                r_col <= '0;
                                r_row <= r_row + (IW+1)'(1);
                            end else begin
                                r_col <= r_col + (IW+1)'(1);
                            end
                        end
                    end
                end
                S_ACC: begin
                    // phases: 0 read A[i][j]; then per k: 1 read L[i][k], 2 read L[j][k]
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    unique case (r_ph)
                        2'd0: r_acc <= r_rd;
                        2'd1: r_opa <= r_rd;
                        default: r_prod <= 64'(r_opa) * 64'(r_rd);
                    endcase
                    r_prod_v <= (r_ph == 2'd2);
                    r_state  <= S_SUB;
                end
                S_SUB: begin
                    if (r_prod_v)
                        r_acc <= chf_pkg::sat34(34'(r_acc) - 34'(chf_pkg::qscale(r_prod)));
                    r_prod_v <= 1'b0;
                    if (r_ph == 2'd1) begin
                        r_ph <= 2'd2;
                        r_state <= S_ACC;
                    end else begin
                        if (r_ph == 2'd2) r_k <= r_k + IW'(1);
                        if ((r_ph == 2'd0 && r_j == '0) ||
                            (r_ph == 2'd2 && r_k + IW'(1) == r_j)) begin
                            r_state <= S_OPER;
                        end else begin
                            r_ph <= 2'd1;
                            r_state <= S_ACC;
                        end
                    end
                end
                S_OPER: begin
                    if (r_i == r_j && r_acc <= 0) r_err <= 1'b1;
                    if (a_start) r_state <= S_WAIT;
                    else begin
                        if (r_i == r_j) r_diag <= 32'sd0;
                        r_state <= S_RD;
                    end
                end
                S_WAIT: begin
                    if (a_done) begin
                        if (r_i == r_j) r_diag <= a_res;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // advance to next (i, j)
                    r_k  <= '0;
                    r_ph <= 2'd0;
                    if (last_i) begin
                        if ({1'b0, r_j} == n - (IW+1)'(1)) begin
                            r_di <= '0;
                            r_dj <= '0;
                            r_drd <= 1'b0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_j <= r_j + IW'(1);
                            r_i <= r_j + IW'(1);
                            r_state <= S_ACC;
                        end
                    end else begin
                        r_i <= r_i + IW'(1);
                        r_state <= S_ACC;
                    end
                end
                S_DRAIN: begin
                    // read issued for (di,dj); data valid next cycle
                    if (!r_drd) begin
                        r_drd <= 1'b1;
                    end else if (out_free) begin
                        r_ofv   <= (r_dj <= r_di) ? r_rd : 32'sd0;
                        r_onpd  <= r_err;
                        r_drd   <= 1'b0;
                        if ({1'b0, r_dj} == n - (IW+1)'(1)) begin
                            r_dj <= '0;
                            if (last_i_d) begin
                                r_olast <= 1'b1;
                                r_state <= S_LOAD;
                            end else begin
                                r_olast <= 1'b0;
                                r_di <= r_di + IW'(1);
                            end
                        end else begin
                            r_olast <= 1'b0;
                            r_dj <= r_dj + IW'(1);
                        end
                    end
                end
            endcase
        end
    end

    assign o_valid                 = r_ov;
    assign o_factor_value          = r_ofv;
    assign o_is_last               = r_olast;
    assign o_not_positive_definite = r_onpd;
endmodule

// ----- design/chf_arith.sv -----
// Multi-cycle square root and divide unit for the Cholesky factor block.
module chf_arith (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_is_sqrt,   // 1: sqrt(a << F); 0: (a << F) / d
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_d,
    output logic               o_done,
    output logic signed [31:0] o_result
);
    // sqrt: restoring one result bit per cycle over a 48-bit radicand (24 steps)
    // div : one quotient bit per cycle over a 48-bit dividend (48 steps)
    logic        r_busy, n_busy;
    logic        r_sq;
    logic [5:0]  r_cnt;
    logic [47:0] r_x;      // radicand or dividend shift register
    logic [49:0] r_rem;
    logic [47:0] r_q;
    logic [30:0] r_den;
    logic        r_neg;
    logic        r_done;

    logic [49:0] sq_trial, sq_rem_sh, dv_rem_sh;
    logic [47:0] q_abs;
    logic [31:0] mag;

    assign mag       = i_a[31] ? (~i_a + 32'd1) : i_a;
    assign sq_rem_sh = {r_rem[47:0], r_x[47:46]};
    assign sq_trial  = {r_q[47:0], 2'b01};
    assign dv_rem_sh = {r_rem[48:0], r_x[47]};
    assign n_busy    = i_start ? 1'b1 : (r_busy && r_cnt != 6'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && r_cnt == 6'd0 && !i_start;
        end
        if (i_start) begin
            r_sq  <= i_is_sqrt;
            r_rem <= '0;
            r_q   <= '0;
            r_den <= i_d[30:0];
            r_neg <= i_a[31];
            if (i_is_sqrt) begin
                r_x   <= {i_a, 16'd0};
                r_cnt <= 6'd23;
            end else begin
                r_x   <= {mag, 16'd0};
                r_cnt <= 6'd47;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_sq) begin
                r_x <= {r_x[45:0], 2'b00};
                if (sq_rem_sh >= sq_trial) begin
                    r_rem <= sq_rem_sh - sq_trial;
                    r_q   <= {r_q[46:0], 1'b1};
                end else begin
                    r_rem <= sq_rem_sh;
                    r_q   <= {r_q[46:0], 1'b0};
                end
            end else begin
                r_x <= {r_x[46:0], 1'b0};
                if (dv_rem_sh >= {19'd0, r_den}) begin
                    r_rem <= dv_rem_sh - {19'd0, r_den};
                    r_q   <= {r_q[46:0], 1'b1};
                end else begin
                    r_rem <= dv_rem_sh;
                    r_q   <= {r_q[46:0], 1'b0};
                end
            end
        end
    end

    // a dividend magnitude of 2^31 fits since mag is unsigned 32 bits
    assign q_abs = r_q;
    always_comb begin
        o_result = r_q[31:0];
        if (!r_sq) begin
            if (r_neg) begin
                if (q_abs > 48'h8000_0000) o_result = chf_pkg::QMin;
                else o_result = ~q_abs[31:0] + 32'd1;
            end else if (q_abs > 48'h7FFF_FFFF) begin
                o_result = chf_pkg::QMax;
            end
        end
    end
    assign o_done = r_done;
endmodule

// ----- tb/cholesky_factor_checker.sv -----
// Channel monitor with factor prediction and result comparison.
module cholesky_factor_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic signed [31:0] i_element_value,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_factor_value,
    input  logic               o_is_last,
    input  logic               o_not_positive_definite,
    output int                 fail_count,
    output int                 pending_count
);
    typedef struct {
        logic signed [31:0] value;
        bit                 last;
        bit                 npd;
    } t_factor_item;

    t_factor_item       factor_q[$];
    logic signed [31:0] elem_store[chf_pkg::Cells];
    logic [3:0]         size_reg;
    int                 load_cnt;

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return chf_pkg::QMax;
        if (v < -64'sh8000_0000) return chf_pkg::QMin;
        return v[31:0];
    endfunction

    // floor of product shift, then clip
    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return clip32(p >>> chf_pkg::FracBits);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] fx_div(input logic signed [31:0] num,
                                                  input logic signed [31:0] den);
        logic [63:0] mag;
        logic [63:0] q;
        if (den <= 0) return 0;
        mag = (num < 0) ? 64'(-64'(num)) : 64'(num);
        q = (mag << chf_pkg::FracBits) / 64'(den);
        if (num < 0) begin
            if (q > 64'h8000_0000) return chf_pkg::QMin;
            return clip32(-$signed(q));
        end
        if (q > 64'h7FFF_FFFF) return chf_pkg::QMax;
        return q[31:0];
    endfunction

    function automatic int size_in_use();
        if (size_reg == 0) return 1;
        if (size_reg > chf_pkg::MaxSize) return chf_pkg::MaxSize;
        return int'(size_reg);
    endfunction

    // column-by-column factorization of the loaded lower triangle
    task automatic predict_factor(input int n);
        logic signed [31:0] fac[chf_pkg::Cells];
        logic signed [31:0] acc;
        logic signed [31:0] diag;
        logic signed [31:0] s;
        bit                 npd;
        t_factor_item       it;
        npd = 0;
        for (int c = 0; c < chf_pkg::Cells; c++) fac[c] = 0;
        for (int j = 0; j < n; j++) begin
            acc = elem_store[j*chf_pkg::MaxSize+j];
            diag = 0;
            for (int k = 0; k < j; k++)
                acc = clip32(64'(acc) - 64'(fx_mul(fac[j*chf_pkg::MaxSize+k],
                                                   fac[j*chf_pkg::MaxSize+k])));
            if (acc <= 0) npd = 1;
            else diag = 32'(int_sqrt(64'(acc) << chf_pkg::FracBits));
            fac[j*chf_pkg::MaxSize+j] = diag;
            for (int i = j + 1; i < n; i++) begin
                s = elem_store[i*chf_pkg::MaxSize+j];
                for (int k = 0; k < j; k++)
                    s = clip32(64'(s) - 64'(fx_mul(fac[i*chf_pkg::MaxSize+k],
                                                   fac[j*chf_pkg::MaxSize+k])));
                fac[i*chf_pkg::MaxSize+j] = (diag > 0) ? fx_div(s, diag) : 0;
            end
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                it.value = (j <= i) ? fac[i*chf_pkg::MaxSize+j] : 0;
                it.last  = (i == n - 1) && (j == n - 1);
                it.npd   = npd;
                factor_q.push_back(it);
            end
    endtask

    always @(posedge i_clk) begin
        int           n;
        t_factor_item want;
        if (!i_rst_n) begin
            size_reg   = 4'(chf_pkg::MaxSize);
            load_cnt   = 0;
            fail_count = 0;
            factor_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                size_reg = i_cfg_data;
                load_cnt = 0;
            end
            if (i_valid && !o_stall) begin
                n = size_in_use();
                if (load_cnt >= n * n) load_cnt = 0;
                if (load_cnt % n <= load_cnt / n)
                    elem_store[(load_cnt / n) * chf_pkg::MaxSize + load_cnt % n] =
                        i_element_value;
                load_cnt++;
                if (load_cnt == n * n) begin
                    load_cnt = 0;
                    predict_factor(n);
                end
            end
            if (o_valid && !i_stall) begin
                if (factor_q.size() == 0) begin
                    $error("factor item with none expected: value %0d", o_factor_value);
                    fail_count++;
                end else begin
                    want = factor_q.pop_front();
                    if (o_factor_value !== want.value) begin
                        $error("factor_value: expected %0d, got %0d", want.value, o_factor_value);
                        fail_count++;
                    end
                    if (o_is_last !== want.last) begin
                        $error("is_last: expected %0d, got %0d", want.last, o_is_last);
                        fail_count++;
                    end
                    if (o_not_positive_definite !== want.npd) begin
                        $error("not_positive_definite: expected %0d, got %0d",
                               want.npd, o_not_positive_definite);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = factor_q.size();
    end
endmodule

// ----- tb/tb_cholesky_factor_top.sv -----
// Stimulus and verdict for the Cholesky factor block.
module tb_cholesky_factor_top;
    localparam int CycleLimit = 400000;
    localparam int HoldCycles = 3000;   // long receiver hold-off to fill the block

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_element_value;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_data;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_factor_value;
    logic               o_is_last;
    logic               o_not_positive_definite;

    int fail_count;
    int pending_count;
    int cycle_cnt;
    int elems_sent;
    bit calm;       // no idling on either side while set
    bit hold_req;   // asks the receiver for one long hold-off

    logic signed [31:0] mat[chf_pkg::MaxSize][chf_pkg::MaxSize];

    cholesky_factor_top u_dut (.*);

    cholesky_factor_checker u_chk (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // give up if the block never drains
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CycleLimit) begin
                $display("cholesky_factor_top test failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1;
                for (int c = 0; c < HoldCycles; c++) @(negedge i_clk);
                hold_req = 0;
            end
            i_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 35);
        end
    end

    // one element item; idle gaps before it, held until accepted
    task automatic send_elem(input logic signed [31:0] v);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 35) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid         <= 1;
        i_element_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        elems_sent++;
    endtask

    // wait for every expected item, then let the block settle before a write
    task automatic drain_idle();
        @(negedge i_clk);
        i_valid <= 0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [3:0] sz);
        drain_idle();
        i_cfg_valid <= 1;
        i_cfg_data  <= sz;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic send_matrix(input int n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) send_elem(mat[r][c]);
    endtask

    // kind 0: diagonally dominant (positive definite), 1: small random, 2: full noise
    task automatic make_matrix(input int n, input int kind);
        int sum;
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= r; c++) begin
                case (kind)
                    0:       mat[r][c] = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
                    1:       mat[r][c] = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
                    default: mat[r][c] = $urandom;
                endcase
                // upper triangle is dropped by the block; feed garbage there for kind 2
                mat[c][r] = (kind == 2) ? $urandom : mat[r][c];
                if (c == r) mat[c][r] = mat[r][c];
            end
        if (kind == 0) begin
            for (int r = 0; r < n; r++) begin
                sum = 0;
                for (int c = 0; c < n; c++)
                    if (c != r) sum += (mat[r][c] < 0) ? -mat[r][c] : mat[r][c];
                mat[r][r] = sum + $urandom_range(1 << 12, 1 << 18);
            end
        end
    endtask

    initial begin
        int n;
        int kind;
        logic [3:0] sz;
        i_rst_n         = 0;
        i_valid         = 0;
        i_element_value = 0;
        i_cfg_valid     = 0;
        i_cfg_data      = 0;
        calm            = 0;
        hold_req        = 0;
        elems_sent      = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;

        // 1x1: unit, zero and negative radicands, both extremes
        write_size(4'd1);
        send_elem(32'sh0001_0000);
        send_elem(32'sh0000_0000);
        send_elem(32'sh8000_0000);
        send_elem(32'sh7FFF_FFFF);
        // size zero acts as one
        write_size(4'd0);
        send_elem(32'sh0004_0000);
        // 2x2 well formed: [4 2; 2 3], upper entry junk
        write_size(4'd2);
        send_elem(32'sh0004_0000);
        send_elem(32'sh7FFF_FFFF);
        send_elem(32'sh0002_0000);
        send_elem(32'sh0003_0000);
        // 2x2 with a negative second radicand: later column zeroed
        send_elem(32'sh0001_0000);
        send_elem(32'sh0000_0000);
        send_elem(32'sh0004_0000);
        send_elem(32'sh0001_0000);
        // zero first diagonal: whole column zero, later column reads zeros
        send_elem(32'sh0000_0000);
        send_elem(32'sh0000_0000);
        send_elem(32'shFFFF_0000);
        send_elem(32'sh0002_0000);
        // partial load, then a write discards it
        send_elem(32'sh0009_0000);
        send_elem(32'sh0001_0000);
        write_size(4'd3);
        make_matrix(3, 0);
        send_matrix(3);

        // size too large acts as eight; receiver holds off while the block fills,
        // and a second matrix is offered while the drain is blocked
        write_size(4'd15);
        make_matrix(8, 0);
        calm     = 1;
        hold_req = 1;
        send_matrix(8);
        calm = 0;
        make_matrix(8, 0);
        send_matrix(8);

        while (elems_sent < 160) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: n = $urandom_range(1, 4);
                6, 7, 8:          n = $urandom_range(5, 7);
                default:          n = 8;
            endcase
            sz = 4'(n);
            if (n == 1 && $urandom_range(0, 1)) sz = 4'd0;
            if (n == 8 && $urandom_range(0, 1)) sz = 4'd15;
            kind = $urandom_range(0, 99);
            kind = (kind < 70) ? 0 : (kind < 85) ? 1 : 2;
            write_size(sz);
            make_matrix(n, kind);
            send_matrix(n);
        end

        drain_idle();
        repeat (100) @(negedge i_clk);
        if (fail_count == 0)
            $display("cholesky_factor_top test passed");
        else
            $display("cholesky_factor_top test failed");
        $finish;
    end
endmodule
